>>> src/pru_pkg.sv
`default_nettype none

package pru_pkg;

  // Sizing of the line store and the enlargement factor.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_FACTOR  = 64;
  localparam int QUEUE_DEPTH = 4;

  // Derived widths.
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RPL_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  // Configuration register widths and indexes.
  localparam int SW_W      = 11;
  localparam int SF_W      = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = SW_W;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'd1;

  // Input command codes.
  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_REPLAY = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       command;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;
    logic [1:0] pad_count;
    logic       run_last;
    logic       bad_command;
  } result_t;

  // One classified input item: a pixel to be sent out factor times.
  typedef struct packed {
    pixel_t          pixel;
    logic [SF_W-1:0] factor;
    logic            ends;
    logic [1:0]      pad;
    logic            bad;
  } run_t;

endpackage

`default_nettype wire

>>> src/pru_ram.sv
`default_nettype none

module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  wire logic [WIDTH-1:0]                 wdata,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write, or registered read that holds until the next read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/pru_fifo.sv
`default_nettype none

module pru_fifo
  import pru_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire run_t wdata,
  input  wire logic pop,
  output run_t      rdata,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  run_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Run queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Run queue read while empty.");
`endif

endmodule

`default_nettype wire

>>> src/pru_front.sv
`default_nettype none

module pru_front
  import pru_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      push,
  output run_t                      push_run,
  input  wire logic                 fifo_full
);

  logic [SW_W-1:0]  source_width;
  logic [SF_W-1:0]  scale_factor;
  logic [COL_W-1:0] column;
  logic [RPL_W-1:0] replays_left;

  logic             s1_valid;
  run_t             s1_run;
  logic             s1_from_ram;

  logic [SW_W-1:0]  eff_w;
  logic [SF_W-1:0]  eff_f;
  logic             ends;
  logic [3:0]       wf_low;
  logic [1:0]       pad;
  logic             accept;
  logic             is_pixel;
  logic             bad;
  pixel_t           in_pixel;
  logic [$bits(pixel_t)-1:0] ram_rdata;

  assign cfg_ready  = 1'b1;
  assign item_stall = s1_valid && fifo_full;
  assign accept     = item_valid && !item_stall;
  assign push       = s1_valid && !fifo_full;
  assign is_pixel   = (item.command == CMD_PIXEL);

  // Clamp the registers into their working ranges.
  always_comb begin
    priority if (source_width == '0) begin
      eff_w = SW_W'(1);
    end else if (32'(source_width) > MAX_WIDTH) begin
      eff_w = SW_W'(MAX_WIDTH);
    end else begin
      eff_w = source_width;
    end
    priority if (scale_factor == '0) begin
      eff_f = SF_W'(1);
    end else if (32'(scale_factor) > MAX_FACTOR) begin
      eff_f = SF_W'(MAX_FACTOR);
    end else begin
      eff_f = scale_factor;
    end
  end

  // Row end and padding. Three bytes a pixel makes the pad (w * f) mod 4.
  always_comb begin
    ends   = (32'(column) + 32'd1 >= 32'(eff_w));
    wf_low = {2'b00, eff_w[1:0]} * {2'b00, eff_f[1:0]};
    pad    = wf_low[1:0];
  end

  // A pixel while replays are owed, or a tick with none owed, is an error.
  assign bad = is_pixel ? (replays_left != '0) : (replays_left == '0);

  assign in_pixel.red   = item.red_in;
  assign in_pixel.green = item.green_in;
  assign in_pixel.blue  = item.blue_in;

  pru_ram #(
    .WIDTH($bits(pixel_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .en   (accept && !bad),
    .we   (is_pixel),
    .addr (column),
    .wdata(in_pixel),
    .rdata(ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= SW_W'(1);
      scale_factor <= SF_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH: source_width <= cfg_data;
        REG_SCALE_FACTOR: scale_factor <= cfg_data[SF_W-1:0];
        default: ;
      endcase
    end
  end

  // Row position moves on every good transaction, owed replays at a row end.
  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      replays_left <= '0;
    end else if (accept && !bad) begin
      column <= ends ? '0 : column + COL_W'(1);
      if (ends) begin
        replays_left <= is_pixel ? RPL_W'(eff_f - SF_W'(1))
                                 : replays_left - RPL_W'(1);
      end
    end
  end

  // Stage register between classification and the run queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_from_ram <= !bad && !is_pixel;
      if (bad) begin
        s1_run.pixel  <= '0;
        s1_run.factor <= SF_W'(1);
        s1_run.ends   <= 1'b0;
        s1_run.pad    <= '0;
        s1_run.bad    <= 1'b1;
      end else begin
        s1_run.pixel  <= in_pixel;
        s1_run.factor <= eff_f;
        s1_run.ends   <= ends;
        s1_run.pad    <= pad;
        s1_run.bad    <= 1'b0;
      end
    end
  end

  // Replay ticks take their pixel from the line store read.
  always_comb begin
    push_run = s1_run;
    if (s1_from_ram) begin
      push_run.pixel = ram_rdata;
    end
  end

`ifndef ASSERT_OFF
  a_pixel_while_owed: assert property (@(posedge clk) disable iff (rst)
    accept && is_pixel && (replays_left != '0) |=> s1_run.bad)
    else $error("Pixel accepted while replays owed was not flagged.");
  a_replays_at_row_end: assert property (@(posedge clk) disable iff (rst)
    accept && !ends |=> replays_left == $past(replays_left))
    else $error("Owed replays changed away from a row end.");
`endif

endmodule

`default_nettype wire

>>> src/pru_back.sv
`default_nettype none

module pru_back
  import pru_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire run_t head,
  input  wire logic empty,
  output logic      pop,
  output logic      result_valid,
  input  wire logic result_stall,
  output result_t   result
);

  logic [RPL_W-1:0] copy;
  logic             last;
  logic             advance;

  assign advance = !result_valid || !result_stall;
  assign last    = head.bad || (SF_W'(copy) + SF_W'(1) >= head.factor);
  assign pop     = advance && !empty && last;

  // Copy counter across one run.
  always_ff @(posedge clk) begin
    if (rst) begin
      copy         <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= !empty;
      if (!empty) begin
        copy <= last ? '0 : copy + RPL_W'(1);
      end
    end
  end

  // Output register: loads the next copy whenever a run is queued and not stalled.
  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      result.blue_out    <= head.pixel.blue;
      result.green_out   <= head.pixel.green;
      result.red_out     <= head.pixel.red;
      result.row_end     <= last && head.ends && !head.bad;
      result.pad_count   <= (last && head.ends && !head.bad) ? head.pad : 2'd0;
      result.run_last    <= last;
      result.bad_command <= head.bad;
    end
  end

`ifndef ASSERT_OFF
  a_pop_on_run_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> result_valid && result.run_last)
    else $error("Run retired without a result marked as its last.");
`endif

endmodule

`default_nettype wire

>>> src/pixel_replication_upscaler.sv
// Integer nearest-neighbor upscaler for rows of 24-bit pixels.
// Item channel (item_valid / item_stall / item): command 0 carries a source
// pixel, which is stored in the line buffer and sent out scale_factor times;
// command 1 is a replay tick that sends out scale_factor copies of the next
// buffered pixel. After a row ends, scale_factor-1 replay rows are owed.
// A pixel while replays are owed, or a tick with none owed, gives one result
// with bad_command set.
// Result channel (result_valid / result_stall / result): one result per cycle
// from the output register while unstalled with a run queued; run_last marks
// the last result of an item, row_end and pad_count the end of an output row.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; the user writes it only while idle; the block does not enforce it.
// The first result of an item passes the stage register, the queue and the
// output register. An item gives scale_factor results (one for an error),
// counted by the output stage's copy counter before it takes the next item;
// the stage register and a four-entry queue hold classified items ahead of
// it. When the receiver stalls, the result holds and the queue fills, after
// which item_stall rises. Reset clears the row position, the owed replays and
// the queue, and sets both registers to 1; the line buffer is not cleared.
`default_nettype none

module pixel_replication_upscaler
  import pru_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result
);

  logic push;
  logic pop;
  logic fifo_full;
  logic fifo_empty;
  run_t push_run;
  run_t head_run;

  // Classification, row tracking and the line buffer.
  pru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .push      (push),
    .push_run  (push_run),
    .fifo_full (fifo_full)
  );

  // Queue of runs between the two sides.
  pru_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(push_run),
    .pop  (pop),
    .rdata(head_run),
    .full (fifo_full),
    .empty(fifo_empty)
  );

  // Copy generation and output register.
  pru_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_run),
    .empty       (fifo_empty),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

`default_nettype wire
